// File: hdl/bbrm_pkg.sv
`default_nettype none

package bbrm_pkg;

  localparam int unsigned BUF_BYTES_MAX = 65536;
  // Largest buffer_size the offset fields can describe.
  localparam int unsigned SIZE_CAP = (BUF_BYTES_MAX < 65536) ? BUF_BYTES_MAX : 65536;

  typedef enum logic [2:0] {
    CMD_WR_ACQ = 3'd0,
    CMD_WR_REL = 3'd1,
    CMD_RD_ACQ = 3'd2,
    CMD_RD_REL = 3'd3,
    CMD_PEEK   = 3'd4,
    CMD_CLEAR  = 3'd5
  } cmd_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [16:0] amount;
    logic [15:0] peek_offset;
  } req_t;

  typedef struct packed {
    logic        ok;
    logic [15:0] region_start;
    logic [16:0] region_len;
  } rsp_t;

endpackage

`default_nettype wire

// File: hdl/bbrm_req_if.sv
`default_nettype none

interface bbrm_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [16:0] amount;
  logic [15:0] peek_offset;

  modport source (output valid, output cmd, output amount, output peek_offset, input ready);
  modport sink (input valid, input cmd, input amount, input peek_offset, output ready);
endinterface

`default_nettype wire

// File: hdl/bbrm_rsp_if.sv
`default_nettype none

interface bbrm_rsp_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic [15:0] region_start;
  logic [16:0] region_len;

  modport source (output valid, output ok, output region_start, output region_len, input ready);
  modport sink (input valid, input ok, input region_start, input region_len, output ready);
endinterface

`default_nettype wire

// File: hdl/bbrm_core.sv
`default_nettype none

module bbrm_core
  import bbrm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [16:0] cfg_wdata,
  input  logic        fire,
  input  req_t        req,
  output rsp_t        rsp
);

  localparam logic [16:0] CAP17 = 17'(SIZE_CAP);

  logic [16:0] buf_size_r, buf_size_nxt;
  logic [15:0] a_start_r, a_start_nxt, b_start_r, b_start_nxt, resv_start_r, resv_start_nxt;
  logic [16:0] a_len_r, a_len_nxt, b_len_r, b_len_nxt, resv_len_r, resv_len_nxt;

  logic [17:0] a_end, b_end, free_a, free_b;
  logic [16:0] rel_n, peek_n;

  always_comb begin
    a_end  = {2'b0, a_start_r} + {1'b0, a_len_r};
    b_end  = {2'b0, b_start_r} + {1'b0, b_len_r};
    free_b = ({2'b0, a_start_r} > b_end) ? ({2'b0, a_start_r} - b_end) : 18'd0;
    free_a = ({1'b0, buf_size_r} > a_end) ? ({1'b0, buf_size_r} - a_end) : 18'd0;
    rel_n  = (req.amount < resv_len_r) ? req.amount : resv_len_r;
    peek_n = {1'b0, req.peek_offset} - a_len_r;

    buf_size_nxt   = buf_size_r;
    a_start_nxt    = a_start_r;
    a_len_nxt      = a_len_r;
    b_start_nxt    = b_start_r;
    b_len_nxt      = b_len_r;
    resv_start_nxt = resv_start_r;
    resv_len_nxt   = resv_len_r;
    rsp            = '0;

    case (req.cmd)
      CMD_WR_ACQ: begin
        if (b_len_r != 17'd0) begin
          if (free_b == 18'd0) begin
            resv_start_nxt = '0;
            resv_len_nxt   = '0;
          end else begin
            resv_start_nxt = b_end[15:0];
            resv_len_nxt   = free_b[16:0];
          end
        end else if (free_a >= {2'b0, a_start_r}) begin
          if (free_a == 18'd0) begin
            resv_start_nxt = '0;
            resv_len_nxt   = '0;
          end else begin
            resv_start_nxt = a_end[15:0];
            resv_len_nxt   = free_a[16:0];
          end
        end else begin
          // The front gap is larger than the space after A.
          resv_start_nxt = '0;
          resv_len_nxt   = {1'b0, a_start_r};
        end
        rsp.ok           = (resv_len_nxt != 17'd0);
        rsp.region_start = resv_start_nxt;
        rsp.region_len   = resv_len_nxt;
      end
      CMD_WR_REL: begin
        if (rel_n != 17'd0) begin
          if (a_len_r == 17'd0 && b_len_r == 17'd0) begin
            a_start_nxt = resv_start_r;
            a_len_nxt   = rel_n;
          end else if ({2'b0, resv_start_r} == a_end) begin
            a_len_nxt = a_len_r + rel_n;
          end else begin
            if (b_len_r == 17'd0) begin
              b_start_nxt = resv_start_r;
            end
            b_len_nxt = b_len_r + rel_n;
          end
        end
        resv_start_nxt = '0;
        resv_len_nxt   = '0;
        rsp.ok         = 1'b1;
      end
      CMD_RD_ACQ: begin
        if (a_len_r != 17'd0) begin
          rsp.ok           = 1'b1;
          rsp.region_start = a_start_r;
          rsp.region_len   = a_len_r;
        end
      end
      CMD_RD_REL: begin
        if (req.amount < a_len_r) begin
          a_len_nxt   = a_len_r - req.amount;
          a_start_nxt = a_start_r + req.amount[15:0];
        end else begin
          // A is used up, so the wrapped region becomes the oldest data.
          a_start_nxt = b_start_r;
          a_len_nxt   = b_len_r;
          b_start_nxt = '0;
          b_len_nxt   = '0;
        end
        rsp.ok = 1'b1;
      end
      CMD_PEEK: begin
        if ({1'b0, req.peek_offset} < a_len_r) begin
          rsp.ok           = 1'b1;
          rsp.region_start = a_start_r + req.peek_offset;
          rsp.region_len   = a_len_r - {1'b0, req.peek_offset};
        end else if (peek_n < b_len_r) begin
          rsp.ok           = 1'b1;
          rsp.region_start = b_start_r + peek_n[15:0];
          rsp.region_len   = b_len_r - peek_n;
        end
      end
      CMD_CLEAR: begin
        a_start_nxt    = '0;
        a_len_nxt      = '0;
        b_start_nxt    = '0;
        b_len_nxt      = '0;
        resv_start_nxt = '0;
        resv_len_nxt   = '0;
        rsp.ok         = 1'b1;
      end
      default: begin
      end
    endcase

    if (cfg_we) begin
      if (cfg_wdata == 17'd0) begin
        buf_size_nxt = 17'd1;
      end else if (cfg_wdata > CAP17) begin
        buf_size_nxt = CAP17;
      end else begin
        buf_size_nxt = cfg_wdata;
      end
      a_start_nxt    = '0;
      a_len_nxt      = '0;
      b_start_nxt    = '0;
      b_len_nxt      = '0;
      resv_start_nxt = '0;
      resv_len_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_size_r   <= CAP17;
      a_start_r    <= '0;
      a_len_r      <= '0;
      b_start_r    <= '0;
      b_len_r      <= '0;
      resv_start_r <= '0;
      resv_len_r   <= '0;
    end else if (fire || cfg_we) begin
      buf_size_r   <= buf_size_nxt;
      a_start_r    <= a_start_nxt;
      a_len_r      <= a_len_nxt;
      b_start_r    <= b_start_nxt;
      b_len_r      <= b_len_nxt;
      resv_start_r <= resv_start_nxt;
      resv_len_r   <= resv_len_nxt;
    end
  end

  a_size_range: assert property (@(posedge clk) disable iff (!rst_n)
    buf_size_r != 17'd0 && buf_size_r <= CAP17)
    else $error("buffer size out of range");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && !cfg_we && req.cmd == CMD_CLEAR) |=> (a_len_r == 17'd0 && b_len_r == 17'd0
      && resv_len_r == 17'd0))
    else $error("clear left regions behind");

  a_release_drops_resv: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && !cfg_we && req.cmd == CMD_WR_REL) |=> (resv_len_r == 17'd0))
    else $error("reservation survived a write release");

  a_fail_is_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && !rsp.ok) |-> (rsp.region_start == 16'd0 && rsp.region_len == 17'd0))
    else $error("failed request reports a region");

endmodule

`default_nettype wire

// File: hdl/bip_buffer_region_manager.sv
// Offset bookkeeping for a bipartite circular buffer: region A, region B and
// one write reservation. One request is accepted every cycle while the result
// side keeps up. Each accepted request is held in the input register while the
// single compute stage between it and the result register does all region
// arithmetic, and its result then waits in the result register until it is
// taken. The state is updated as a request leaves the input register, so
// back-to-back requests see each other's effects in order. Writing buffer_size
// clears all regions and must only be done while no request is in flight.
`default_nettype none

module bip_buffer_region_manager
  import bbrm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [16:0] cfg_wdata,
  bbrm_req_if.sink    in_req,
  bbrm_rsp_if.source  out_rsp
);

  logic s1_v_r, s1_v_nxt;
  req_t s1_req_r;
  logic out_v_r, out_v_nxt;
  rsp_t out_rsp_r;
  rsp_t core_rsp;
  logic adv;
  logic in_fire;

  assign adv          = s1_v_r && (!out_v_r || out_rsp.ready);
  assign in_req.ready = !s1_v_r || adv;
  assign in_fire      = in_req.valid && in_req.ready;

  assign s1_v_nxt  = in_fire ? 1'b1 : (adv ? 1'b0 : s1_v_r);
  assign out_v_nxt = adv ? 1'b1 : (out_rsp.ready ? 1'b0 : out_v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_req_r.cmd         <= in_req.cmd;
      s1_req_r.amount      <= in_req.amount;
      s1_req_r.peek_offset <= in_req.peek_offset;
    end
    if (adv) begin
      out_rsp_r <= core_rsp;
    end
  end

  bbrm_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .fire      (adv),
    .req       (s1_req_r),
    .rsp       (core_rsp)
  );

  assign out_rsp.valid        = out_v_r;
  assign out_rsp.ok           = out_rsp_r.ok;
  assign out_rsp.region_start = out_rsp_r.region_start;
  assign out_rsp.region_len   = out_rsp_r.region_len;

endmodule

`default_nettype wire

// File: tb/bip_buffer_region_manager_tb.sv
`timescale 1ns / 100ps

module bip_buffer_region_manager_tb;
  import bbrm_pkg::*;

  localparam logic [2:0] CMD_RSVD6 = 3'd6;
  localparam logic [2:0] CMD_RSVD7 = 3'd7;
  localparam int unsigned STALL_LIMIT = 2000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [16:0] cfg_wdata = '0;

  bbrm_req_if in_req_ch ();
  bbrm_rsp_if out_rsp_ch ();

  bip_buffer_region_manager dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_req   (in_req_ch),
    .out_rsp  (out_rsp_ch)
  );

  always #4 clk = ~clk;

  // Shadow copy of the region bookkeeping.
  int unsigned buf_bytes;
  int unsigned a_off, a_cnt, b_off, b_cnt, rsv_off, rsv_cnt;

  rsp_t expected_rsp[$];
  int unsigned err_count = 0;
  int unsigned req_count = 0;
  int unsigned rsp_count = 0;
  int unsigned size_writes = 0;
  int unsigned quiet_cycles = 0;
  bit src_gaps_on = 1'b1;
  bit sink_stalls_on = 1'b1;

  function automatic void clear_regions();
    a_off = 0; a_cnt = 0;
    b_off = 0; b_cnt = 0;
    rsv_off = 0; rsv_cnt = 0;
  endfunction

  function automatic void apply_size(input logic [16:0] v);
    int unsigned s;
    s = 32'(v);
    if (s < 1) s = 1;
    if (s > SIZE_CAP) s = SIZE_CAP;
    buf_bytes = s;
    clear_regions();
  endfunction

  // Updates the shadow regions for one request and returns its result.
  function automatic rsp_t apply_request(input logic [2:0] c, input logic [16:0] amt,
                                         input logic [15:0] off);
    int unsigned span, n, amount_u, off_u;
    rsp_t r;
    r = '0;
    amount_u = 32'(amt);
    off_u = 32'(off);
    case (c)
      CMD_WR_ACQ: begin
        if (b_cnt != 0) begin
          span = (a_off > b_off + b_cnt) ? a_off - (b_off + b_cnt) : 0;
          if (span == 0) begin
            rsv_off = 0; rsv_cnt = 0;
          end else begin
            rsv_off = (b_off + b_cnt) & 32'hFFFF;
            rsv_cnt = span & 32'h1FFFF;
            r.ok = 1'b1;
          end
        end else begin
          span = (buf_bytes > a_off + a_cnt) ? buf_bytes - (a_off + a_cnt) : 0;
          if (span >= a_off) begin
            if (span == 0) begin
              rsv_off = 0; rsv_cnt = 0;
            end else begin
              rsv_off = (a_off + a_cnt) & 32'hFFFF;
              rsv_cnt = span & 32'h1FFFF;
              r.ok = 1'b1;
            end
          end else begin
            // The gap in front of A is larger, so the write wraps to offset 0.
            rsv_off = 0;
            rsv_cnt = a_off;
            r.ok = 1'b1;
          end
        end
        if (r.ok) begin
          r.region_start = rsv_off[15:0];
          r.region_len = rsv_cnt[16:0];
        end
      end
      CMD_WR_REL: begin
        n = (amount_u < rsv_cnt) ? amount_u : rsv_cnt;
        if (n != 0) begin
          if (a_cnt == 0 && b_cnt == 0) begin
            a_off = rsv_off;
            a_cnt = n;
          end else if (rsv_off == a_off + a_cnt) begin
            a_cnt = (a_cnt + n) & 32'h1FFFF;
          end else begin
            if (b_cnt == 0) b_off = rsv_off;
            b_cnt = (b_cnt + n) & 32'h1FFFF;
          end
        end
        rsv_off = 0; rsv_cnt = 0;
        r.ok = 1'b1;
      end
      CMD_RD_ACQ: begin
        if (a_cnt != 0) begin
          r.ok = 1'b1;
          r.region_start = a_off[15:0];
          r.region_len = a_cnt[16:0];
        end
      end
      CMD_RD_REL: begin
        if (amount_u < a_cnt) begin
          a_cnt = a_cnt - amount_u;
          a_off = (a_off + amount_u) & 32'hFFFF;
        end else begin
          a_off = b_off; a_cnt = b_cnt;
          b_off = 0; b_cnt = 0;
        end
        r.ok = 1'b1;
      end
      CMD_PEEK: begin
        if (off_u < a_cnt) begin
          r.ok = 1'b1;
          r.region_start = 16'(a_off + off_u);
          r.region_len = 17'(a_cnt - off_u);
        end else begin
          n = off_u - a_cnt;
          if (n < b_cnt) begin
            r.ok = 1'b1;
            r.region_start = 16'(b_off + n);
            r.region_len = 17'(b_cnt - n);
          end
        end
      end
      CMD_CLEAR: begin
        clear_regions();
        r.ok = 1'b1;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  task automatic send_req(input logic [2:0] c, input logic [16:0] amt,
                          input logic [15:0] off);
    int unsigned gap;
    gap = src_gaps_on ? $urandom_range(0, 17) : 0;
    if (gap != 0) begin
      in_req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_req_ch.valid <= 1'b1;
    in_req_ch.cmd <= c;
    in_req_ch.amount <= amt;
    in_req_ch.peek_offset <= off;
    do @(posedge clk); while (!in_req_ch.ready);
    expected_rsp.push_back(apply_request(c, amt, off));
    req_count++;
  endtask

  task automatic write_size(input logic [16:0] v);
    in_req_ch.valid <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    apply_size(v);
    size_writes++;
  endtask

  function automatic logic [16:0] any_amount();
    return 17'($urandom_range(0, 17'h1FFFF));
  endfunction

  function automatic logic [15:0] any_offset();
    return 16'($urandom_range(0, 16'hFFFF));
  endfunction

  // Result side: per-result random stall, then check against the oldest request.
  int unsigned hold_cycles = 0;
  rsp_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_rsp_ch.ready <= 1'b0;
      hold_cycles = 0;
    end else begin
      if (out_rsp_ch.valid && out_rsp_ch.ready) begin
        rsp_count++;
        if (expected_rsp.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual ok=%0d start=%0d len=%0d",
                   $time, out_rsp_ch.ok, out_rsp_ch.region_start, out_rsp_ch.region_len);
          err_count++;
        end else begin
          want = expected_rsp.pop_front();
          if (out_rsp_ch.ok !== want.ok) begin
            $display("%0t: ok mismatch: expected %0d actual %0d",
                     $time, want.ok, out_rsp_ch.ok);
            err_count++;
          end
          if (out_rsp_ch.region_start !== want.region_start) begin
            $display("%0t: region_start mismatch: expected %0d actual %0d",
                     $time, want.region_start, out_rsp_ch.region_start);
            err_count++;
          end
          if (out_rsp_ch.region_len !== want.region_len) begin
            $display("%0t: region_len mismatch: expected %0d actual %0d",
                     $time, want.region_len, out_rsp_ch.region_len);
            err_count++;
          end
        end
        hold_cycles = sink_stalls_on ? $urandom_range(0, 17) : 0;
      end else if (hold_cycles > 0) begin
        hold_cycles--;
      end
      out_rsp_ch.ready <= (hold_cycles == 0);
    end
  end

  always @(posedge clk) begin
    if ((in_req_ch.valid && in_req_ch.ready) || (out_rsp_ch.valid && out_rsp_ch.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no request or result moved for %0d cycles", $time, quiet_cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Full-size buffer after reset: empty reads, a full fill and a large consume.
  task automatic test_reset_size();
    send_req(CMD_RD_ACQ, any_amount(), any_offset());
    send_req(CMD_PEEK, any_amount(), 16'd0);
    send_req(CMD_WR_ACQ, any_amount(), any_offset());
    send_req(CMD_WR_REL, 17'd65536, any_offset());
    send_req(CMD_WR_ACQ, any_amount(), any_offset());
    send_req(CMD_PEEK, any_amount(), 16'hFFFF);
    send_req(CMD_RD_REL, 17'd65535, any_offset());
  endtask

  // Small buffer: wrap into the front gap, grow B, run out of space, promote B.
  task automatic test_region_lifecycle();
    write_size(17'd16);
    send_req(CMD_WR_ACQ, any_amount(), any_offset());
    send_req(CMD_WR_REL, 17'h1FFFF, any_offset());
    send_req(CMD_RD_REL, 17'd10, any_offset());
    send_req(CMD_WR_ACQ, any_amount(), any_offset());
    send_req(CMD_WR_REL, 17'd4, any_offset());
    send_req(CMD_WR_ACQ, any_amount(), any_offset());
    send_req(CMD_WR_REL, 17'd6, any_offset());
    send_req(CMD_WR_ACQ, any_amount(), any_offset());
    send_req(CMD_PEEK, any_amount(), 16'd5);
    send_req(CMD_PEEK, any_amount(), 16'd8);
    send_req(CMD_PEEK, any_amount(), 16'd16);
    send_req(CMD_RD_ACQ, any_amount(), any_offset());
    send_req(CMD_RD_REL, 17'd6, any_offset());
    send_req(CMD_RSVD6, any_amount(), any_offset());
    send_req(CMD_RSVD7, any_amount(), any_offset());
    send_req(CMD_CLEAR, any_amount(), any_offset());
  endtask

  task automatic random_produce();
    logic [16:0] amt;
    send_req(CMD_WR_ACQ, any_amount(), any_offset());
    if (rsv_cnt != 0 && $urandom_range(0, 4) != 0)
      amt = 17'($urandom_range(1, rsv_cnt));
    else if ($urandom_range(0, 1) != 0)
      amt = 17'(rsv_cnt + $urandom_range(0, 3));
    else
      amt = any_amount();
    send_req(CMD_WR_REL, amt, any_offset());
  endtask

  task automatic random_consume();
    logic [16:0] amt;
    send_req(CMD_RD_ACQ, any_amount(), any_offset());
    if (a_cnt != 0 && $urandom_range(0, 4) != 0)
      amt = 17'($urandom_range(1, a_cnt));
    else
      amt = any_amount();
    send_req(CMD_RD_REL, amt, any_offset());
  endtask

  task automatic random_peek();
    int unsigned total;
    logic [15:0] off;
    total = a_cnt + b_cnt;
    if (total != 0 && $urandom_range(0, 3) != 0)
      off = 16'($urandom_range(0, (total > 65536) ? 65535 : total - 1));
    else
      off = any_offset();
    send_req(CMD_PEEK, any_amount(), off);
  endtask

  task automatic test_random_traffic();
    logic [16:0] sizes[10];
    int unsigned first, pick;
    sizes = '{17'd0, 17'd2, 17'd16, 17'h1FFFF, 17'd255, 17'd1, 17'd65535, 17'd100,
              17'd65536, 17'd7};
    foreach (sizes[i]) begin
      write_size(sizes[i]);
      first = req_count;
      while (req_count - first < 138) begin
        if ($urandom_range(0, 24) == 0) begin
          src_gaps_on = ($urandom_range(0, 2) != 0);
          sink_stalls_on = ($urandom_range(0, 2) != 0);
        end
        pick = $urandom_range(0, 99);
        if (pick < 35)
          random_produce();
        else if (pick < 65)
          random_consume();
        else if (pick < 85)
          random_peek();
        else
          send_req(3'($urandom_range(0, 7)), any_amount(), any_offset());
      end
    end
  endtask

  initial begin
    in_req_ch.valid = 1'b0;
    in_req_ch.cmd = CMD_CLEAR;
    in_req_ch.amount = '0;
    in_req_ch.peek_offset = '0;
    out_rsp_ch.ready = 1'b0;
    buf_bytes = SIZE_CAP;
    clear_regions();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_size();
    test_region_lifecycle();
    test_random_traffic();

    in_req_ch.valid <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d requests and checked %0d results across %0d buffer size settings,",
             req_count, rsp_count, size_writes);
    $display("from a single byte to the full range, with saturated size writes included.");
    if (err_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
